FILE: rtl/core/bfdr_pkg.sv
// ----------------------------------------------------------------------------
// bfdr_pkg
// Shared types and constants of the binary frame deframer with resync.
// ----------------------------------------------------------------------------
package bfdr_pkg;

  // default ring size in bytes
  localparam int unsigned RingBytes   = 4096;
  // largest payload that a frame may carry
  localparam int unsigned MaxPayload  = 1022;
  // depth of the command queue between front and back
  localparam int unsigned QueueDepth  = 2;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 10;
  localparam int unsigned WordW   = 16;
  localparam int unsigned OffW    = 11;
  localparam int unsigned ReqW    = 2;
  localparam int unsigned StatusW = 2;

  localparam logic [LenW-1:0] LimitReset = 10'd1023;

  // frame marks
  localparam logic [ByteW-1:0] Sync0 = 8'hA0;
  localparam logic [ByteW-1:0] Sync1 = 8'hA2;
  localparam logic [ByteW-1:0] End0  = 8'hB0;
  localparam logic [ByteW-1:0] End1  = 8'hB3;

  // request codes
  localparam logic [ReqW-1:0] ReqPush = 2'd0;
  localparam logic [ReqW-1:0] ReqFind = 2'd1;
  localparam logic [ReqW-1:0] ReqRead = 2'd2;

  // status codes
  localparam logic [StatusW-1:0] StDone  = 2'd0;
  localparam logic [StatusW-1:0] StFound = 2'd1;
  localparam logic [StatusW-1:0] StNone  = 2'd2;
  localparam logic [StatusW-1:0] StFull  = 2'd3;

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_FIND,
    OP_READ,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [ByteW-1:0] data_byte;
    logic [LenW-1:0]  read_index;
  } cmd_t;

  typedef struct packed {
    logic               valid;
    logic [StatusW-1:0] status;
    logic [ByteW-1:0]   payload_data;
    logic [LenW-1:0]    frame_length;
    logic [WordW-1:0]   frame_checksum;
    logic [WordW-1:0]   skipped_count;
  } res_t;

endpackage

FILE: rtl/core/bfdr_ram.sv
// ----------------------------------------------------------------------------
// bfdr_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfdr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/bfdr_front.sv
// ----------------------------------------------------------------------------
// bfdr_front
// Accepts requests, decodes them into commands and queues them for the back
// end; also holds the length limit register.
// ----------------------------------------------------------------------------
module bfdr_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [bfdr_pkg::ReqW-1:0]     req_type_i,
  input  logic [bfdr_pkg::ByteW-1:0]    data_byte_i,
  input  logic [bfdr_pkg::LenW-1:0]     read_index_i,
  input  logic                          cfg_we_i,
  input  logic [bfdr_pkg::LenW-1:0]     cfg_wdata_i,
  output logic [bfdr_pkg::LenW-1:0]     length_limit_o,
  output logic                          cmd_valid_o,
  output bfdr_pkg::cmd_t                cmd_o,
  input  logic                          cmd_pop_i
);

  localparam int unsigned QAW = (bfdr_pkg::QueueDepth > 1) ? $clog2(bfdr_pkg::QueueDepth) : 1;
  localparam int unsigned QCW = $clog2(bfdr_pkg::QueueDepth + 1);

  bfdr_pkg::cmd_t  queue_q [bfdr_pkg::QueueDepth];
  logic [QAW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0]  count_q, count_d;
  logic [bfdr_pkg::LenW-1:0] limit_q;
  logic            push;
  bfdr_pkg::cmd_t  cmd_new;

  assign busy_o      = (count_q == QCW'(bfdr_pkg::QueueDepth));
  assign push        = start_i && !busy_o;
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];
  assign length_limit_o = limit_q;

  // classify the request
  always_comb begin
    cmd_new.data_byte  = data_byte_i;
    cmd_new.read_index = read_index_i;
    unique case (req_type_i)
      bfdr_pkg::ReqPush: cmd_new.op = bfdr_pkg::OP_PUSH;
      bfdr_pkg::ReqFind: cmd_new.op = bfdr_pkg::OP_FIND;
      bfdr_pkg::ReqRead: cmd_new.op = bfdr_pkg::OP_READ;
      default:           cmd_new.op = bfdr_pkg::OP_NOP;
    endcase
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QAW'(bfdr_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (cmd_pop_i) begin
      rd_ptr_d = (rd_ptr_q == QAW'(bfdr_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !cmd_pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push && cmd_pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      limit_q  <= bfdr_pkg::LimitReset;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

FILE: rtl/core/bfdr_back.sv
// ----------------------------------------------------------------------------
// bfdr_back
// Executes queued commands against the byte ring: push, frame scan with
// resync, and payload read of the held frame.
// ----------------------------------------------------------------------------
module bfdr_back #(
  parameter int unsigned RING_BYTES = bfdr_pkg::RingBytes
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cmd_valid_i,
  input  bfdr_pkg::cmd_t            cmd_i,
  output logic                      cmd_pop_o,
  input  logic [bfdr_pkg::LenW-1:0] length_limit_i,
  output bfdr_pkg::res_t            res_o
);

  localparam int unsigned PW = $clog2(RING_BYTES);
  localparam int unsigned FW = $clog2(RING_BYTES + 1);
  localparam int unsigned OW = bfdr_pkg::OffW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_READ
  } state_e;

  state_e                      state_q, state_d;
  logic [2:0]                  step_q, step_d;
  logic [PW-1:0]               sp_q, sp_d;
  logic [PW-1:0]               wp_q, wp_d;
  logic [FW-1:0]               fill_q, fill_d;
  logic [PW-1:0]               base_q, base_d;
  logic [bfdr_pkg::LenW-1:0]   hold_len_q, hold_len_d;
  logic [OW-1:0]               held_q, held_d;
  logic [bfdr_pkg::WordW-1:0]  skip_q, skip_d;
  logic [bfdr_pkg::LenW-1:0]   len_q, len_d;
  logic [bfdr_pkg::ByteW-1:0]  hi_q, hi_d;
  bfdr_pkg::res_t              res_q, res_d;

  logic                        ram_we;
  logic [PW-1:0]               ram_raddr;
  logic [bfdr_pkg::ByteW-1:0]  ram_rdata;
  logic [OW-1:0]               need;
  logic [OW-1:0]               off;
  logic [bfdr_pkg::WordW-1:0]  len_word;
  logic                        need_more;
  logic                        drop;

  // pointer plus offset, wrapped at the ring size (offset below ring size)
  function automatic logic [PW-1:0] ring_add(input logic [PW-1:0] ptr, input logic [OW-1:0] ofs);
    logic [PW:0] sum;
    sum = {1'b0, ptr} + (PW+1)'(ofs);
    if (sum >= (PW+1)'(RING_BYTES)) begin
      sum = sum - (PW+1)'(RING_BYTES);
    end
    return sum[PW-1:0];
  endfunction

  bfdr_ram #(
    .WIDTH (bfdr_pkg::ByteW),
    .DEPTH (RING_BYTES)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (cmd_i.data_byte),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign need     = {1'b0, len_q} + OW'(8);
  assign len_word = {hi_q, ram_rdata};

  // ring offset of the byte examined at each scan step
  always_comb begin
    unique case (step_q)
      3'd0:    off = OW'(0);
      3'd1:    off = OW'(1);
      3'd2:    off = OW'(2);
      3'd3:    off = OW'(3);
      3'd4:    off = {1'b0, len_q} + OW'(6);
      3'd5:    off = {1'b0, len_q} + OW'(7);
      3'd6:    off = {1'b0, len_q} + OW'(4);
      default: off = {1'b0, len_q} + OW'(5);
    endcase
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    sp_d       = sp_q;
    wp_d       = wp_q;
    fill_d     = fill_q;
    base_d     = base_q;
    hold_len_d = hold_len_q;
    held_d     = held_q;
    skip_d     = skip_q;
    len_d      = len_q;
    hi_d       = hi_q;
    res_d      = '0;
    cmd_pop_o  = 1'b0;
    ram_we     = 1'b0;
    ram_raddr  = ring_add(sp_q, off);
    need_more  = 1'b0;
    drop       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.op)
            bfdr_pkg::OP_PUSH: begin
              res_d.valid = 1'b1;
              if (fill_q >= FW'(RING_BYTES)) begin
                res_d.status = bfdr_pkg::StFull;
              end else begin
                ram_we       = 1'b1;
                wp_d         = ring_add(wp_q, OW'(1));
                fill_d       = fill_q + 1'b1;
                res_d.status = bfdr_pkg::StDone;
              end
            end
            bfdr_pkg::OP_FIND: begin
              // release the held frame
              fill_d     = fill_q - FW'(held_q);
              held_d     = '0;
              hold_len_d = '0;
              base_d     = '0;
              step_d     = 3'd0;
              state_d    = S_ISSUE;
            end
            bfdr_pkg::OP_READ: begin
              if (cmd_i.read_index < hold_len_q) begin
                ram_raddr = ring_add(base_q, {1'b0, cmd_i.read_index});
                state_d   = S_READ;
              end else begin
                res_d.valid  = 1'b1;
                res_d.status = bfdr_pkg::StDone;
              end
            end
            bfdr_pkg::OP_NOP: begin
              res_d.valid  = 1'b1;
              res_d.status = bfdr_pkg::StDone;
            end
          endcase
        end
      end
      S_ISSUE: begin
        need_more = ((step_q == 3'd0) && (fill_q < FW'(2))) ||
                    ((step_q == 3'd2) && (fill_q < FW'(4))) ||
                    ((step_q == 3'd4) && (fill_q < FW'(need)));
        if (need_more) begin
          res_d.valid  = 1'b1;
          res_d.status = bfdr_pkg::StNone;
          state_d      = S_IDLE;
        end else begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        state_d = S_ISSUE;
        step_d  = step_q + 1'b1;
        unique case (step_q)
          3'd0: drop = (ram_rdata != bfdr_pkg::Sync0);
          3'd1: drop = (ram_rdata != bfdr_pkg::Sync1);
          3'd2: hi_d = ram_rdata;
          3'd3: begin
            drop  = (len_word >= bfdr_pkg::WordW'(length_limit_i)) ||
                    (len_word > bfdr_pkg::WordW'(bfdr_pkg::MaxPayload));
            len_d = len_word[bfdr_pkg::LenW-1:0];
          end
          3'd4: drop = (ram_rdata != bfdr_pkg::End0);
          3'd5: drop = (ram_rdata != bfdr_pkg::End1);
          3'd6: hi_d = ram_rdata;
          default: begin
            res_d.valid          = 1'b1;
            res_d.status         = bfdr_pkg::StFound;
            res_d.frame_length   = len_q;
            res_d.frame_checksum = {hi_q, ram_rdata};
            res_d.skipped_count  = skip_q;
            skip_d     = '0;
            base_d     = ring_add(sp_q, OW'(4));
            hold_len_d = len_q;
            held_d     = need;
            sp_d       = ring_add(sp_q, need);
            state_d    = S_IDLE;
          end
        endcase
        // failed candidate: drop one byte and rescan
        if (drop) begin
          sp_d    = ring_add(sp_q, OW'(1));
          fill_d  = fill_q - 1'b1;
          skip_d  = (skip_q != '1) ? skip_q + 1'b1 : skip_q;
          step_d  = 3'd0;
        end
      end
      S_READ: begin
        res_d.valid        = 1'b1;
        res_d.status       = bfdr_pkg::StDone;
        res_d.payload_data = ram_rdata;
        state_d            = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      step_q     <= '0;
      sp_q       <= '0;
      wp_q       <= '0;
      fill_q     <= '0;
      base_q     <= '0;
      hold_len_q <= '0;
      held_q     <= '0;
      skip_q     <= '0;
      len_q      <= '0;
      hi_q       <= '0;
      res_q      <= '0;
    end else begin
      state_q    <= state_d;
      step_q     <= step_d;
      sp_q       <= sp_d;
      wp_q       <= wp_d;
      fill_q     <= fill_d;
      base_q     <= base_d;
      hold_len_q <= hold_len_d;
      held_q     <= held_d;
      skip_q     <= skip_d;
      len_q      <= len_d;
      hi_q       <= hi_d;
      res_q      <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

FILE: rtl/core/binary_frame_deframer_resync_unit.sv
// ----------------------------------------------------------------------------
// binary_frame_deframer_resync_unit
// Byte ring deframer: A0 A2, length, payload, checksum, B0 B3, with resync.
// ----------------------------------------------------------------------------
// Requests are taken when start_i is high and busy_o is low and go through a
// two-entry command queue, so a new request is taken while the previous one
// is still being carried out. Every request gives one result, shown for one
// cycle with result_valid_o; the receiver cannot stall it. A push, an unused
// code or an out-of-range read is finished in the idle state of the execution
// unit; an in-range read goes on to a read state (registered ring read).
// A frame request examines ring bytes one at a time through the single read
// port, each byte in an issue and a wait state: the two sync bytes, the two
// length bytes, then end mark and checksum of a valid candidate. The ring
// needs no clearing after reset.
module binary_frame_deframer_resync_unit #(
  parameter int unsigned RING_BYTES = bfdr_pkg::RingBytes
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [bfdr_pkg::ReqW-1:0]     req_type_i,
  input  logic [bfdr_pkg::ByteW-1:0]    data_byte_i,
  input  logic [bfdr_pkg::LenW-1:0]     read_index_i,
  input  logic                          cfg_we_i,
  input  logic [bfdr_pkg::LenW-1:0]     cfg_wdata_i,
  output logic                          result_valid_o,
  output logic [bfdr_pkg::StatusW-1:0]  status_o,
  output logic [bfdr_pkg::ByteW-1:0]    payload_data_o,
  output logic [bfdr_pkg::LenW-1:0]     frame_length_o,
  output logic [bfdr_pkg::WordW-1:0]    frame_checksum_o,
  output logic [bfdr_pkg::WordW-1:0]    skipped_count_o
);

  logic                      cmd_valid;
  logic                      cmd_pop;
  bfdr_pkg::cmd_t            cmd;
  logic [bfdr_pkg::LenW-1:0] length_limit;
  bfdr_pkg::res_t            res;

  bfdr_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .req_type_i     (req_type_i),
    .data_byte_i    (data_byte_i),
    .read_index_i   (read_index_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .length_limit_o (length_limit),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd),
    .cmd_pop_i      (cmd_pop)
  );

  bfdr_back #(
    .RING_BYTES (RING_BYTES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .cmd_pop_o      (cmd_pop),
    .length_limit_i (length_limit),
    .res_o          (res)
  );

  assign result_valid_o   = res.valid;
  assign status_o         = res.status;
  assign payload_data_o   = res.payload_data;
  assign frame_length_o   = res.frame_length;
  assign frame_checksum_o = res.frame_checksum;
  assign skipped_count_o  = res.skipped_count;

endmodule

FILE: rtl/core/bfdr_checker.sv
// ----------------------------------------------------------------------------
// bfdr_checker
// Port-level checks of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module bfdr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input logic                          result_valid_o,
  input logic [bfdr_pkg::StatusW-1:0]  status_o,
  input logic [bfdr_pkg::ByteW-1:0]    payload_data_o,
  input logic [bfdr_pkg::LenW-1:0]     frame_length_o,
  input logic [bfdr_pkg::WordW-1:0]    frame_checksum_o,
  input logic [bfdr_pkg::WordW-1:0]    skipped_count_o
);

  // frame fields only come with a found frame
  a_frame_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (status_o != bfdr_pkg::StFound) |->
      (frame_length_o == '0) && (frame_checksum_o == '0) && (skipped_count_o == '0))
    else $error("frame fields set without a found frame");

  // payload bytes only come with a plain done status
  a_read_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (status_o != bfdr_pkg::StDone) |-> (payload_data_o == '0))
    else $error("payload byte set on a non-read result");

  a_found_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (status_o == bfdr_pkg::StFound) |->
      (frame_length_o <= bfdr_pkg::LenW'(bfdr_pkg::MaxPayload)))
    else $error("found frame longer than the payload limit");

  // the queue only fills up on a taken request
  a_busy_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy rose without a request");

endmodule

bind binary_frame_deframer_resync_unit bfdr_checker u_bfdr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start_i          (start_i),
  .busy_o           (busy_o),
  .result_valid_o   (result_valid_o),
  .status_o         (status_o),
  .payload_data_o   (payload_data_o),
  .frame_length_o   (frame_length_o),
  .frame_checksum_o (frame_checksum_o),
  .skipped_count_o  (skipped_count_o)
);
